>>> hdl/mlfq_pkg.sv
`timescale 1ns / 1ps

package mlfq_pkg;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  slot;
		logic [1:0]  next_state;
		logic [31:0] channel;
		logic [1:0]  new_priority;
	} in_item_t;

	typedef struct packed {
		logic [5:0] chosen_slot;
		logic       granted;
		logic [1:0] status;
	} out_item_t;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_ADMIT    = 3'd1;
	localparam logic [2:0] OP_DISPATCH = 3'd2;
	localparam logic [2:0] OP_RELEASE  = 3'd3;
	localparam logic [2:0] OP_WAKE     = 3'd4;
	localparam logic [2:0] OP_SETPRIO  = 3'd5;

	localparam logic [1:0] NS_RUNNABLE = 2'd0;
	localparam logic [1:0] NS_SLEEP    = 2'd1;
	localparam logic [1:0] NS_EXIT     = 2'd2;
	localparam logic [1:0] NS_BAD      = 2'd3;

	localparam logic [1:0] SS_UNUSED = 2'd0;
	localparam logic [1:0] SS_READY  = 2'd1;
	localparam logic [1:0] SS_RUN    = 2'd2;
	localparam logic [1:0] SS_SLEEP  = 2'd3;

	localparam logic [1:0] RS_OK    = 2'd0;
	localparam logic [1:0] RS_EMPTY = 2'd1;
	localparam logic [1:0] RS_WRONG = 2'd2;

	localparam logic [4:0] U_NONE      = 5'd0;
	localparam logic [4:0] U_TICK      = 5'd1;
	localparam logic [4:0] U_RD        = 5'd2;
	localparam logic [4:0] U_RD_PREV   = 5'd3;
	localparam logic [4:0] U_ERR       = 5'd4;
	localparam logic [4:0] U_EMPTY     = 5'd5;
	localparam logic [4:0] U_ADMIT     = 5'd6;
	localparam logic [4:0] U_PUSH      = 5'd7;
	localparam logic [4:0] U_PROM0     = 5'd8;
	localparam logic [4:0] U_PROM_STEP = 5'd9;
	localparam logic [4:0] U_POP_SEL   = 5'd10;
	localparam logic [4:0] U_POP_FIN   = 5'd11;
	localparam logic [4:0] U_REL_EL    = 5'd12;
	localparam logic [4:0] U_REL_B     = 5'd13;
	localparam logic [4:0] U_WAKE_SET  = 5'd14;
	localparam logic [4:0] U_NEXT      = 5'd15;
	localparam logic [4:0] U_SP_SET    = 5'd16;
	localparam logic [4:0] U_UL_HEAD   = 5'd17;
	localparam logic [4:0] U_UL_FIX    = 5'd18;
	localparam logic [4:0] U_UL_ADV    = 5'd19;
	localparam logic [4:0] U_SP_LVL    = 5'd20;

	typedef struct packed {
		logic       load;
		logic [4:0] uop;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       bad;
		logic       due;
		logic       none;
		logic       match;
		logic       move;
		logic       hit_head;
		logic       hit_link;
		logic       prev_tail;
		logic       last;
		logic       ns_run;
	} dp_flags_t;

endpackage

>>> hdl/mlfq_ctrl.sv
`timescale 1ns / 1ps

module mlfq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2:0]            in_op,
	input  logic                  out_space,
	input  mlfq_pkg::dp_flags_t   flags,
	output logic                  in_ready,
	output logic                  out_load,
	output mlfq_pkg::dp_cmd_t     cmd
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_TICK    = 5'd1;
	localparam logic [4:0] S_RD      = 5'd2;
	localparam logic [4:0] S_CHK     = 5'd3;
	localparam logic [4:0] S_REL_B   = 5'd4;
	localparam logic [4:0] S_PUSH    = 5'd5;
	localparam logic [4:0] S_DISP    = 5'd6;
	localparam logic [4:0] S_PR      = 5'd7;
	localparam logic [4:0] S_PW      = 5'd8;
	localparam logic [4:0] S_POP_SEL = 5'd9;
	localparam logic [4:0] S_POP_RD  = 5'd10;
	localparam logic [4:0] S_POP_FIN = 5'd11;
	localparam logic [4:0] S_WR      = 5'd12;
	localparam logic [4:0] S_WCHK    = 5'd13;
	localparam logic [4:0] S_WNXT    = 5'd14;
	localparam logic [4:0] S_UL_HEAD = 5'd15;
	localparam logic [4:0] S_UL_RD   = 5'd16;
	localparam logic [4:0] S_UL_CHK  = 5'd17;
	localparam logic [4:0] S_SP_LVL  = 5'd18;
	localparam logic [4:0] S_DONE    = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.uop  = mlfq_pkg::U_NONE;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_op) inside
						mlfq_pkg::OP_TICK: state_d = S_TICK;
						mlfq_pkg::OP_ADMIT, mlfq_pkg::OP_RELEASE,
						mlfq_pkg::OP_SETPRIO: state_d = S_RD;
						mlfq_pkg::OP_DISPATCH: state_d = S_DISP;
						mlfq_pkg::OP_WAKE: state_d = S_WR;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_TICK: begin
				cmd.uop = mlfq_pkg::U_TICK;
				state_d = S_DONE;
			end
			S_RD: begin
				cmd.uop = mlfq_pkg::U_RD;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (flags.bad) begin
					cmd.uop = mlfq_pkg::U_ERR;
					state_d = S_DONE;
				end else begin
					case (flags.op)
						mlfq_pkg::OP_ADMIT: begin
							cmd.uop = mlfq_pkg::U_ADMIT;
							state_d = S_PUSH;
						end
						mlfq_pkg::OP_RELEASE: begin
							cmd.uop = mlfq_pkg::U_REL_EL;
							state_d = S_REL_B;
						end
						default: begin
							cmd.uop = mlfq_pkg::U_SP_SET;
							state_d = flags.move ? S_UL_HEAD : S_DONE;
						end
					endcase
				end
			end
			S_REL_B: begin
				cmd.uop = mlfq_pkg::U_REL_B;
				state_d = flags.ns_run ? S_PUSH : S_DONE;
			end
			S_PUSH: begin
				cmd.uop = mlfq_pkg::U_PUSH;
				state_d = (flags.op == mlfq_pkg::OP_WAKE) ? S_WNXT : S_DONE;
			end
			S_DISP: begin
				if (flags.due) begin
					cmd.uop = mlfq_pkg::U_PROM0;
					state_d = S_PR;
				end else begin
					state_d = S_POP_SEL;
				end
			end
			S_PR: begin
				cmd.uop = mlfq_pkg::U_RD;
				state_d = S_PW;
			end
			S_PW: begin
				cmd.uop = mlfq_pkg::U_PROM_STEP;
				state_d = flags.last ? S_POP_SEL : S_PR;
			end
			S_POP_SEL: begin
				if (flags.none) begin
					cmd.uop = mlfq_pkg::U_EMPTY;
					state_d = S_DONE;
				end else begin
					cmd.uop = mlfq_pkg::U_POP_SEL;
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				cmd.uop = mlfq_pkg::U_RD;
				state_d = S_POP_FIN;
			end
			S_POP_FIN: begin
				cmd.uop = mlfq_pkg::U_POP_FIN;
				state_d = S_DONE;
			end
			S_WR: begin
				cmd.uop = mlfq_pkg::U_RD;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (flags.match) begin
					cmd.uop = mlfq_pkg::U_WAKE_SET;
					state_d = S_PUSH;
				end else if (flags.last) begin
					state_d = S_DONE;
				end else begin
					cmd.uop = mlfq_pkg::U_NEXT;
					state_d = S_WR;
				end
			end
			S_WNXT: begin
				if (flags.last) begin
					state_d = S_DONE;
				end else begin
					cmd.uop = mlfq_pkg::U_NEXT;
					state_d = S_WR;
				end
			end
			S_UL_HEAD: begin
				cmd.uop = mlfq_pkg::U_UL_HEAD;
				state_d = flags.hit_head ? S_SP_LVL : S_UL_RD;
			end
			S_UL_RD: begin
				cmd.uop = mlfq_pkg::U_RD_PREV;
				state_d = S_UL_CHK;
			end
			S_UL_CHK: begin
				if (flags.prev_tail) begin
					state_d = S_SP_LVL;
				end else if (flags.hit_link) begin
					cmd.uop = mlfq_pkg::U_UL_FIX;
					state_d = S_SP_LVL;
				end else begin
					cmd.uop = mlfq_pkg::U_UL_ADV;
					state_d = S_UL_RD;
				end
			end
			S_SP_LVL: begin
				cmd.uop = mlfq_pkg::U_SP_LVL;
				state_d = S_PUSH;
			end
			S_DONE: begin
				if (out_space) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hdl/mlfq_dp.sv
`timescale 1ns / 1ps

module mlfq_dp #(
	parameter int NUM_SLOTS  = 64,
	parameter int NUM_LEVELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mlfq_pkg::dp_cmd_t     cmd,
	input  mlfq_pkg::in_item_t    in_data,
	input  logic [15:0]           budget_ticks,
	input  logic [15:0]           promote_interval,
	output mlfq_pkg::dp_flags_t   flags,
	output mlfq_pkg::out_item_t   result
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int MW = LW + 2;

	mlfq_pkg::in_item_t  item_q;
	mlfq_pkg::out_item_t res_q;
	logic [SW-1:0]       cur_q;
	logic [SW-1:0]       prev_q;
	logic [SW-1:0]       nxt_q;
	logic [LW-1:0]       lvl_q;
	logic [31:0]         el_q;
	logic [31:0]         tick_q;
	logic [31:0]         promote_at_q;
	logic [SW-1:0]       head_q [NUM_LEVELS];
	logic [SW-1:0]       tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] hv_q;

	logic [MW-1:0]       meta_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] meta_vld_q;
	logic [31:0]         bud_mem   [NUM_SLOTS];
	logic [31:0]         start_mem [NUM_SLOTS];
	logic [31:0]         chan_mem  [NUM_SLOTS];
	logic [SW-1:0]       link_mem  [NUM_SLOTS];

	logic [MW-1:0]       meta_rd_q;
	logic [31:0]         bud_rd_q;
	logic [31:0]         start_rd_q;
	logic [31:0]         chan_rd_q;
	logic [SW-1:0]       link_rd_q;

	logic [1:0]          st_rd;
	logic [LW-1:0]       pr_rd;
	logic                slot_bad;
	logic [LW-1:0]       np_sat;
	logic [31:0]         full;
	logic [31:0]         b_new;
	logic                demote;
	logic [LW-1:0]       pr_rel;
	logic [1:0]          st_rel;
	logic [LW-1:0]       pick;
	logic [SW-1:0]       lvl_tail;
	logic [SW-1:0]       lvl_head;
	logic                cur_is_tail;
	logic                rd_en;
	logic [SW-1:0]       rd_addr;
	logic                meta_we;
	logic [MW-1:0]       meta_wd;
	logic                bud_we;
	logic [31:0]         bud_wd;
	logic                start_we;
	logic                chan_we;
	logic                link_we;
	logic [SW-1:0]       link_wa;
	logic [SW-1:0]       link_wd;

	assign st_rd       = meta_rd_q[MW-1 -: 2];
	assign pr_rd       = meta_rd_q[LW-1:0];
	assign slot_bad    = 32'(item_q.slot) >= 32'(NUM_SLOTS);
	assign np_sat      = (32'(item_q.new_priority) >= 32'(NUM_LEVELS)) ?
		LW'(NUM_LEVELS - 1) : LW'(item_q.new_priority);
	assign full        = {16'b0, budget_ticks};
	assign b_new       = bud_rd_q - el_q;
	assign demote      = ((b_new == 32'd0) || b_new[31]) && (pr_rd != LW'(NUM_LEVELS - 1));
	assign pr_rel      = demote ? pr_rd + LW'(1) : pr_rd;
	assign lvl_tail    = tail_q[lvl_q];
	assign lvl_head    = head_q[lvl_q];
	assign cur_is_tail = cur_q == lvl_tail;
	assign rd_en       = (cmd.uop == mlfq_pkg::U_RD) || (cmd.uop == mlfq_pkg::U_RD_PREV);
	assign rd_addr     = (cmd.uop == mlfq_pkg::U_RD_PREV) ? prev_q : cur_q;
	assign result      = res_q;

	always_comb begin
		case (item_q.next_state)
			mlfq_pkg::NS_RUNNABLE: st_rel = mlfq_pkg::SS_READY;
			mlfq_pkg::NS_SLEEP:    st_rel = mlfq_pkg::SS_SLEEP;
			default:               st_rel = mlfq_pkg::SS_UNUSED;
		endcase
	end

	always_comb begin
		pick = '0;
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			if (hv_q[k]) begin
				pick = LW'(k);
			end
		end
	end

	always_comb begin
		flags.op        = item_q.op;
		flags.due       = !(tick_q < promote_at_q);
		flags.none      = ~|hv_q;
		flags.match     = (st_rd == mlfq_pkg::SS_SLEEP) && (chan_rd_q == item_q.channel);
		flags.move      = (st_rd == mlfq_pkg::SS_READY) && (pr_rd != np_sat);
		flags.hit_head  = lvl_head == cur_q;
		flags.hit_link  = link_rd_q == cur_q;
		flags.prev_tail = prev_q == lvl_tail;
		flags.last      = cur_q == SW'(NUM_SLOTS - 1);
		flags.ns_run    = item_q.next_state == mlfq_pkg::NS_RUNNABLE;
		case (item_q.op)
			mlfq_pkg::OP_ADMIT:   flags.bad = slot_bad || (st_rd != mlfq_pkg::SS_UNUSED);
			mlfq_pkg::OP_RELEASE: flags.bad = slot_bad || (st_rd != mlfq_pkg::SS_RUN) ||
				(item_q.next_state == mlfq_pkg::NS_BAD);
			mlfq_pkg::OP_SETPRIO: flags.bad = slot_bad || (st_rd == mlfq_pkg::SS_UNUSED);
			default:              flags.bad = 1'b0;
		endcase
	end

	always_comb begin
		meta_we  = 1'b0;
		meta_wd  = '0;
		bud_we   = 1'b0;
		bud_wd   = full;
		start_we = 1'b0;
		chan_we  = 1'b0;
		link_we  = 1'b0;
		link_wa  = lvl_tail;
		link_wd  = cur_q;
		case (cmd.uop)
			mlfq_pkg::U_ADMIT: begin
				meta_we = 1'b1;
				meta_wd = {mlfq_pkg::SS_READY, LW'(0)};
				bud_we  = 1'b1;
			end
			mlfq_pkg::U_PROM_STEP: begin
				if ((pr_rd != '0) && (st_rd != mlfq_pkg::SS_UNUSED)) begin
					meta_we = 1'b1;
					meta_wd = {st_rd, pr_rd - LW'(1)};
					bud_we  = 1'b1;
				end
			end
			mlfq_pkg::U_POP_FIN: begin
				meta_we  = 1'b1;
				meta_wd  = {mlfq_pkg::SS_RUN, lvl_q};
				start_we = 1'b1;
			end
			mlfq_pkg::U_REL_B: begin
				meta_we = 1'b1;
				meta_wd = {st_rel, pr_rel};
				bud_we  = 1'b1;
				bud_wd  = demote ? full : b_new;
				chan_we = item_q.next_state == mlfq_pkg::NS_SLEEP;
			end
			mlfq_pkg::U_WAKE_SET: begin
				meta_we = 1'b1;
				meta_wd = {mlfq_pkg::SS_READY, pr_rd};
			end
			mlfq_pkg::U_SP_SET: begin
				meta_we = 1'b1;
				meta_wd = {st_rd, np_sat};
				bud_we  = 1'b1;
			end
			mlfq_pkg::U_PUSH: begin
				link_we = hv_q[lvl_q];
			end
			mlfq_pkg::U_PROM0: begin
				link_we = hv_q[0] && hv_q[1];
				link_wa = tail_q[0];
				link_wd = head_q[1];
			end
			mlfq_pkg::U_UL_FIX: begin
				link_we = !cur_is_tail;
				link_wa = prev_q;
				link_wd = nxt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[cur_q] <= meta_wd;
		end
		if (bud_we) begin
			bud_mem[cur_q] <= bud_wd;
		end
		if (start_we) begin
			start_mem[cur_q] <= tick_q;
		end
		if (chan_we) begin
			chan_mem[cur_q] <= item_q.channel;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			meta_rd_q  <= meta_vld_q[rd_addr] ? meta_mem[rd_addr] : '0;
			bud_rd_q   <= bud_mem[rd_addr];
			start_rd_q <= start_mem[rd_addr];
			chan_rd_q  <= chan_mem[rd_addr];
			link_rd_q  <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
		end else if (meta_we) begin
			meta_vld_q[cur_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q         <= '0;
			tick_q       <= '0;
			promote_at_q <= '0;
		end else begin
			case (cmd.uop)
				mlfq_pkg::U_TICK: tick_q <= tick_q + 32'd1;
				mlfq_pkg::U_PROM0: begin
					promote_at_q <= tick_q + {16'b0, promote_interval};
					hv_q[0]      <= hv_q[0] | hv_q[1];
					for (int k = 1; k < NUM_LEVELS - 1; k++) begin
						hv_q[k] <= hv_q[k+1];
					end
					hv_q[NUM_LEVELS-1] <= 1'b0;
				end
				mlfq_pkg::U_PUSH: hv_q[lvl_q] <= 1'b1;
				mlfq_pkg::U_POP_FIN: begin
					if (cur_is_tail) begin
						hv_q[lvl_q] <= 1'b0;
					end
				end
				mlfq_pkg::U_UL_HEAD: begin
					if ((lvl_head == cur_q) && cur_is_tail) begin
						hv_q[lvl_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			cur_q  <= (in_data.op == mlfq_pkg::OP_WAKE) ? '0 : SW'(in_data.slot);
			res_q  <= '0;
		end
		case (cmd.uop)
			mlfq_pkg::U_ERR:   res_q.status <= mlfq_pkg::RS_WRONG;
			mlfq_pkg::U_EMPTY: res_q.status <= mlfq_pkg::RS_EMPTY;
			mlfq_pkg::U_ADMIT: lvl_q <= '0;
			mlfq_pkg::U_PUSH: begin
				if (!hv_q[lvl_q]) begin
					head_q[lvl_q] <= cur_q;
				end
				tail_q[lvl_q] <= cur_q;
			end
			mlfq_pkg::U_PROM0: begin
				cur_q <= '0;
				if (hv_q[1]) begin
					tail_q[0] <= tail_q[1];
					if (!hv_q[0]) begin
						head_q[0] <= head_q[1];
					end
				end
				for (int k = 1; k < NUM_LEVELS - 1; k++) begin
					head_q[k] <= head_q[k+1];
					tail_q[k] <= tail_q[k+1];
				end
			end
			mlfq_pkg::U_PROM_STEP, mlfq_pkg::U_NEXT: cur_q <= cur_q + SW'(1);
			mlfq_pkg::U_POP_SEL: begin
				lvl_q <= pick;
				cur_q <= head_q[pick];
			end
			mlfq_pkg::U_POP_FIN: begin
				if (!cur_is_tail) begin
					head_q[lvl_q] <= link_rd_q;
				end
				res_q.chosen_slot <= 6'(cur_q);
				res_q.granted     <= 1'b1;
				res_q.status      <= mlfq_pkg::RS_OK;
			end
			mlfq_pkg::U_REL_EL:   el_q  <= tick_q - start_rd_q;
			mlfq_pkg::U_REL_B:    lvl_q <= pr_rel;
			mlfq_pkg::U_WAKE_SET: lvl_q <= pr_rd;
			mlfq_pkg::U_SP_SET: begin
				lvl_q <= pr_rd;
				nxt_q <= link_rd_q;
			end
			mlfq_pkg::U_UL_HEAD: begin
				if (lvl_head == cur_q) begin
					if (!cur_is_tail) begin
						head_q[lvl_q] <= nxt_q;
					end
				end else begin
					prev_q <= lvl_head;
				end
			end
			mlfq_pkg::U_UL_FIX: begin
				if (cur_is_tail) begin
					tail_q[lvl_q] <= prev_q;
				end
			end
			mlfq_pkg::U_UL_ADV: prev_q <= link_rd_q;
			mlfq_pkg::U_SP_LVL: lvl_q <= np_sat;
			default: begin
			end
		endcase
	end

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlfq_pkg::U_TICK |=> tick_q == $past(tick_q) + 32'd1)
		else $error("tick counter did not advance");

	a_push_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlfq_pkg::U_PUSH |=>
			hv_q[$past(lvl_q)] && (tail_q[$past(lvl_q)] == $past(cur_q)))
		else $error("pushed slot is not the tail of a non-empty list");

	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlfq_pkg::U_POP_FIN |=>
			res_q.granted && (res_q.status == mlfq_pkg::RS_OK))
		else $error("dispatch finished without a grant");

	a_prom_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlfq_pkg::U_PROM0 |=> !hv_q[NUM_LEVELS-1])
		else $error("lowest list not empty after promotion");

endmodule

>>> hdl/mlfq_process_scheduler_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data (mlfq_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data (mlfq_pkg::out_item_t)
// config    input      APB, pready tied high  budget_ticks at 0x0, promote_interval at 0x4
//
// One item is in work at a time; a transfer on the input is taken only while idle.
// Admit, release and set priority can be refused. Set priority walks the level list to unlink
// a ready slot whose level changes; dispatch first promotes every slot when a promotion is
// due; wake checks every slot in turn.
// A finished result waits until the output register is free; the input is taken again once it is moved there.
// Reset clears the controller, the list valid bits, the counters and the slot valid bits.

module mlfq_process_scheduler_unit #(
	parameter int NUM_SLOTS  = 64,
	parameter int NUM_LEVELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mlfq_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mlfq_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [15:0]          budget_q;
	logic [15:0]          interval_q;
	logic                 out_valid_q;
	mlfq_pkg::out_item_t  out_data_q;
	mlfq_pkg::out_item_t  result;
	mlfq_pkg::dp_cmd_t    cmd;
	mlfq_pkg::dp_flags_t  flags;
	logic                 out_load;
	logic                 out_space;

	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? {16'b0, interval_q} : {16'b0, budget_q};
	assign out_space = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q   <= 16'd100;
			interval_q <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				interval_q <= pwdata[15:0];
			end else begin
				budget_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.out_space (out_space),
		.flags     (flags),
		.in_ready  (in_ready),
		.out_load  (out_load),
		.cmd       (cmd)
	);

	mlfq_dp #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.in_data          (in_data),
		.budget_ticks     (budget_q),
		.promote_interval (interval_q),
		.flags            (flags),
		.result           (result)
	);

endmodule
